>>> rtl/text_console_writer_defines.svh
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS

`define TCW_ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define TCW_ASSERT_NEVER(name, expr, msg) \
    `TCW_ASSERT_CLK(name, !(expr), msg)

`else

`define TCW_ASSERT_CLK(name, prop, msg)

`define TCW_ASSERT_NEVER(name, expr, msg)

`endif

`endif

>>> rtl/tcw_pkg.sv
// Types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int COLOR_W = 4;

    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_OPEN   = 2'd2;
    localparam logic [1:0] PH_NUMBER = 2'd3;

    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } tcw_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              in_escape;
    } tcw_result_t;

    typedef struct packed {
        logic       swallow;
        logic [1:0] phase_next;
    } tcw_esc_t;

endpackage

>>> rtl/tcw_escape.sv
// Escape sequence parser: decides whether a character is swallowed.
`timescale 1ns / 1ps

module tcw_escape
    import tcw_pkg::*;
(
    input  logic [1:0]        phase,
    input  logic [CHAR_W-1:0] char_code,
    output tcw_esc_t          esc
);

    logic is_digit;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

    always_comb
    begin
        esc.swallow    = 1'b0;
        esc.phase_next = PH_NORMAL;
        unique case (phase)
            PH_NORMAL:
            begin
                if (char_code == CH_ESC)
                begin
                    esc.swallow    = 1'b1;
                    esc.phase_next = PH_ESC;
                end
            end
            PH_ESC:
            begin
                if (char_code == CH_OPEN)
                begin
                    esc.swallow    = 1'b1;
                    esc.phase_next = PH_OPEN;
                end
            end
            PH_OPEN:
            begin
                if (is_digit)
                begin
                    esc.swallow    = 1'b1;
                    esc.phase_next = PH_NUMBER;
                end
            end
            PH_NUMBER:
            begin
                if (is_digit)
                begin
                    esc.swallow    = 1'b1;
                    esc.phase_next = PH_NUMBER;
                end
                else if (char_code == CH_SEMI)
                begin
                    esc.swallow    = 1'b1;
                    esc.phase_next = PH_OPEN;
                end
                else if (char_code == CH_M)
                begin
                    esc.swallow    = 1'b1;
                    esc.phase_next = PH_NORMAL;
                end
            end
        endcase
    end

endmodule

>>> rtl/tcw_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/text_console_writer.sv
// Top level of the text console writer: cursor control, screen store and result register.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

// The item channel takes a put (func zero, one character) or a read of one
// screen cell (func one). Every item gives exactly one beat on the result
// channel with the read cell, the cursor after the item and the escape flag.
// Both channels use valid and ready; the config port writes the foreground
// and background colors with no wait and must only be used while idle.
// After acceptance an item decodes and writes or reads the screen store, then
// waits in the finish state until the result slot is free and loads the
// result register; only then is the next item accepted. A put that scrolls
// the screen first passes through a scroll state that makes one store write per
// blanked cell of the new bottom row; scrolling itself only moves a top-row
// pointer, since the store is kept as a ring of rows. A result beat is valid
// once the finish state has loaded the result register.
// After reset the store is cleared one cell per cycle, all
// 2**($clog2(ROWS) + $clog2(COLUMNS)) cells (4096 for 25 by 80); item_ready
// stays low meanwhile. A stalled result holds its register, and the next item
// is still accepted and worked on up to the point where its result is loaded.

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tcw_item_t          item,
    output logic               result_valid,
    input  logic               result_ready,
    output tcw_result_t        result,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [COLOR_W-1:0] cfg_data
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      cursor_x_reg, cursor_x_next;
    logic [RW-1:0]      cursor_y_reg, cursor_y_next;
    logic [RW-1:0]      top_reg, top_next;
    logic [1:0]         phase_reg, phase_next;
    logic [COLOR_W-1:0] fore_reg, back_reg;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [RW-1:0]      scroll_row_reg, scroll_row_next;
    logic [CW-1:0]      scroll_col_reg, scroll_col_next;
    logic               is_read_reg, is_read_next;
    logic               in_range_reg, in_range_next;
    logic               result_valid_reg;
    tcw_result_t        result_reg;

    tcw_esc_t           esc;
    logic               accept;
    logic               slot_free;
    logic [CELL_W-1:0]  attr_cell;
    logic [CELL_W-1:0]  blank;
    logic [RW:0]        wr_sum;
    logic [RW-1:0]      wr_row;
    logic [ROW_W:0]     rd_sum;
    logic [RW-1:0]      rd_row;
    logic               rd_in_range;
    logic               is_bs;
    logic               is_nl;
    logic               advance;
    logic               scroll;
    logic [CW-1:0]      x_print;
    logic [CW-1:0]      x_step;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    tcw_escape u_escape (
        .phase     (phase_reg),
        .char_code (item.char_code),
        .esc       (esc)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign slot_free    = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign attr_cell = {back_reg, fore_reg, item.char_code};
    assign blank     = {back_reg, fore_reg, CH_SPACE};

    assign wr_sum = (RW+1)'(cursor_y_reg) + (RW+1)'(top_reg);
    assign wr_row = (wr_sum >= (RW+1)'(ROWS)) ? RW'(wr_sum - (RW+1)'(ROWS)) : RW'(wr_sum);

    assign rd_sum      = (ROW_W+1)'(item.read_row) + (ROW_W+1)'(top_reg);
    assign rd_row      = (rd_sum >= (ROW_W+1)'(ROWS)) ?
                         RW'(rd_sum - (ROW_W+1)'(ROWS)) : RW'(rd_sum);
    assign rd_in_range = ((ROW_W+1)'(item.read_row) < (ROW_W+1)'(ROWS)) &&
                         ((COL_W+1)'(item.read_col) < (COL_W+1)'(COLUMNS));

    assign is_bs   = (item.char_code == CH_BS);
    assign is_nl   = (item.char_code == CH_NL);
    assign x_print = (is_bs && (cursor_x_reg != '0)) ? cursor_x_reg - CW'(1) : cursor_x_reg;

    always_comb
    begin
        advance = 1'b0;
        if (is_bs)
        begin
            x_step = x_print;
        end
        else if (is_nl)
        begin
            x_step  = '0;
            advance = 1'b1;
        end
        else if (cursor_x_reg == LAST_COL)
        begin
            x_step  = '0;
            advance = 1'b1;
        end
        else
        begin
            x_step = cursor_x_reg + CW'(1);
        end
    end

    assign scroll = advance && (cursor_y_reg == LAST_ROW);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {wr_row, x_print};
        ram_wdata = is_bs ? blank : attr_cell;
        ram_re    = accept && (item.func == FUNC_READ);
        ram_raddr = {rd_row, item.read_col[CW-1:0]};
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_we = accept && (item.func == FUNC_PUT) && !esc.swallow && !is_nl;
            end
            ST_SCROLL:
            begin
                ram_we    = 1'b1;
                ram_waddr = {scroll_row_reg, scroll_col_reg};
                ram_wdata = blank;
            end
            ST_FINISH:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        top_next        = top_reg;
        phase_next      = phase_reg;
        clr_addr_next   = clr_addr_reg;
        scroll_row_next = scroll_row_reg;
        scroll_col_next = scroll_col_reg;
        is_read_next    = is_read_reg;
        in_range_next   = in_range_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_FINISH;
                    is_read_next  = (item.func == FUNC_READ);
                    in_range_next = rd_in_range;
                    if (item.func == FUNC_PUT)
                    begin
                        phase_next = esc.phase_next;
                        if (!esc.swallow)
                        begin
                            cursor_x_next = x_step;
                            if (scroll)
                            begin
                                state_next      = ST_SCROLL;
                                scroll_row_next = top_reg;
                                scroll_col_next = '0;
                                top_next        = (top_reg == LAST_ROW) ? '0 : top_reg + RW'(1);
                            end
                            else if (advance)
                            begin
                                cursor_y_next = cursor_y_reg + RW'(1);
                            end
                        end
                    end
                end
            end
            ST_SCROLL:
            begin
                scroll_col_next = scroll_col_reg + CW'(1);
                if (scroll_col_reg == LAST_COL)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            top_reg          <= '0;
            phase_reg        <= PH_NORMAL;
            clr_addr_reg     <= '0;
            fore_reg         <= 4'hF;
            back_reg         <= 4'h0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            top_reg      <= top_next;
            phase_reg    <= phase_next;
            clr_addr_reg <= clr_addr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FORE: fore_reg <= cfg_data;
                    REG_BACK: back_reg <= cfg_data;
                endcase
            end
            if ((state_reg == ST_FINISH) && slot_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scroll_row_reg <= scroll_row_next;
        scroll_col_reg <= scroll_col_next;
        is_read_reg    <= is_read_next;
        in_range_reg   <= in_range_next;
        if ((state_reg == ST_FINISH) && slot_free)
        begin
            result_reg.cell_value <= (is_read_reg && in_range_reg) ? ram_rdata : '0;
            result_reg.cursor_col <= COL_W'(cursor_x_reg);
            result_reg.cursor_row <= ROW_W'(cursor_y_reg);
            result_reg.in_escape  <= (phase_reg != PH_NORMAL);
        end
    end

    `TCW_ASSERT_CLK(a_row_in_range, cursor_y_reg <= LAST_ROW, "cursor row beyond last row")
    `TCW_ASSERT_CLK(a_accept_busy, accept |=> !item_ready, "item accepted twice in a row")
    `TCW_ASSERT_NEVER(a_no_write_finish, (state_reg == ST_FINISH) && ram_we,
                      "store written while finishing")
    `TCW_ASSERT_CLK(a_scroll_home, (state_reg == ST_SCROLL) |-> (cursor_x_reg == '0),
                    "scroll with cursor off column zero")
    `TCW_ASSERT_CLK(a_result_source, $rose(result_valid_reg) |-> ($past(state_reg) == ST_FINISH),
                    "result without a finished item")

endmodule
